// ===== src/har_pkg.sv =====
`timescale 1ns / 1ps
// Package for the host address resolver: request codes, register indexes,
// field widths and the structs passed between the top level and the table cells.
package har_pkg;

  localparam int unsigned TableDepth = 16;

  localparam int unsigned IpW  = 32;
  localparam int unsigned MacW = 48;
  localparam int unsigned IdxW = 4;
  localparam int unsigned PfxW = 24;
  localparam int unsigned CfgW = 32;

  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_FWD   = 2'd1;
  localparam logic [1:0] REQ_REV   = 2'd2;

  localparam logic CFG_LOCAL_NET = 1'b0;
  localparam logic CFG_GATEWAY   = 1'b1;

  localparam logic [IpW-1:0] LocalhostIp = 32'h7F00_0001;

  // Slot write broadcast to every cell.
  typedef struct packed {
    logic            en;
    logic [IdxW-1:0] index;
    logic            valid;
    logic [IpW-1:0]  ip;
    logic [MacW-1:0] mac;
  } har_wr_t;

  // Search token handed from cell to cell.
  typedef struct packed {
    logic            active;
    logic            rev;
    logic            done;
    logic            hit;
    logic            via;
    logic [IpW-1:0]  key_ip;
    logic [MacW-1:0] key_mac;
    logic [IpW-1:0]  res_ip;
    logic [MacW-1:0] res_mac;
  } har_tok_t;

endpackage

// ===== src/har_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channels of the host address resolver: request and response.
// Depends on har_pkg for field widths.
interface har_req_if import har_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [1:0]      req_type;
  logic [IdxW-1:0] entry_index;
  logic            entry_enable;
  logic [IpW-1:0]  ip_value;
  logic [MacW-1:0] mac_value;
  logic            skip_routing;

  modport source (output valid, req_type, entry_index, entry_enable, ip_value, mac_value,
                  skip_routing, input ready);
  modport sink (input valid, req_type, entry_index, entry_enable, ip_value, mac_value,
                skip_routing, output ready);
endinterface

interface har_rsp_if import har_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            found;
  logic [MacW-1:0] mac_result;
  logic [IpW-1:0]  ip_result;
  logic            via_gateway;

  modport source (output valid, found, mac_result, ip_result, via_gateway, input ready);
  modport sink (input valid, found, mac_result, ip_result, via_gateway, output ready);
endinterface

// ===== src/host_address_resolver.sv =====
`timescale 1ns / 1ps
// Host address resolver: IPv4/MAC host table as a chain of slot cells.
// Writes, localhost and unused request codes: response valid in the cycle after the transfer.
// Lookups: token walks one cell per cycle; response registered when it leaves the last cell;
// one lookup in flight, so the request channel stays busy until the token leaves the last cell.
// Reset clears config registers and all slot valid bits; slot data is undefined until written.
module host_address_resolver import har_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TableDepth
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  har_req_if.sink      req_i,
  har_rsp_if.source    rsp_o,
  input  logic         cfg_we_i,
  input  logic         cfg_index_i,
  input  logic [CfgW-1:0] cfg_data_i
);

  logic [PfxW-1:0] prefix_q;
  logic [IpW-1:0]  gateway_q;
  logic            busy_q;
  logic            rsp_valid_q;
  logic            found_q;
  logic [MacW-1:0] mac_res_q;
  logic [IpW-1:0]  ip_res_q;
  logic            via_q;

  har_tok_t chain [TABLE_DEPTH+1];
  har_tok_t last_tok;
  har_wr_t  wr;

  logic accept;
  logic is_fwd, is_rev, localhost, off_net, launch, direct;

  assign req_i.ready = !busy_q && (!rsp_valid_q || rsp_o.ready);
  assign accept      = req_i.valid && req_i.ready;

  assign is_fwd    = req_i.req_type == REQ_FWD;
  assign is_rev    = req_i.req_type == REQ_REV;
  assign localhost = !req_i.skip_routing && (req_i.ip_value == LocalhostIp);
  assign off_net   = !req_i.skip_routing && !localhost &&
                     (req_i.ip_value[IpW-1:IpW-PfxW] != prefix_q);
  assign launch    = accept && (is_rev || (is_fwd && !localhost));
  assign direct    = accept && !launch;

  assign wr.en    = accept && (req_i.req_type == REQ_WRITE);
  assign wr.index = req_i.entry_index;
  assign wr.valid = req_i.entry_enable;
  assign wr.ip    = req_i.ip_value;
  assign wr.mac   = req_i.mac_value;

  always_comb begin
    chain[0].active  = launch;
    chain[0].rev     = is_rev;
    chain[0].done    = 1'b0;
    chain[0].hit     = 1'b0;
    chain[0].via     = is_fwd && off_net;
    chain[0].key_ip  = (is_fwd && off_net) ? gateway_q : req_i.ip_value;
    chain[0].key_mac = req_i.mac_value;
    chain[0].res_ip  = '0;
    chain[0].res_mac = '0;
  end

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    har_cell #(.CellIdx(g)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .wr_i   (wr),
      .tok_i  (chain[g]),
      .tok_o  (chain[g+1])
    );
  end

  assign last_tok = chain[TABLE_DEPTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_q    <= '0;
      gateway_q   <= '0;
      busy_q      <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_LOCAL_NET: prefix_q  <= cfg_data_i[PfxW-1:0];
          CFG_GATEWAY:   gateway_q <= cfg_data_i[IpW-1:0];
          default:       ;
        endcase
      end
      if (launch) begin
        busy_q <= 1'b1;
      end else if (last_tok.active) begin
        busy_q <= 1'b0;
      end
      if (direct || last_tok.active) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (direct) begin
      found_q   <= is_fwd;
      mac_res_q <= '0;
      ip_res_q  <= '0;
      via_q     <= 1'b0;
    end else if (last_tok.active) begin
      found_q   <= last_tok.hit;
      mac_res_q <= (last_tok.rev || !last_tok.hit) ? '0 : last_tok.res_mac;
      ip_res_q  <= (last_tok.rev && last_tok.hit) ? last_tok.res_ip : '0;
      via_q     <= last_tok.via;
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.found       = found_q;
  assign rsp_o.mac_result  = mac_res_q;
  assign rsp_o.ip_result   = ip_res_q;
  assign rsp_o.via_gateway = via_q;

  a_launch_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    launch |-> !busy_q)
    else $error("lookup launched while chain busy");

  a_exit_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_tok.active |-> busy_q)
    else $error("token left chain with no lookup in flight");

  a_exit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_tok.active |=> !busy_q && rsp_valid_q)
    else $error("finished lookup did not free chain and load response");

  a_no_ready_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !req_i.ready)
    else $error("request ready during lookup");

endmodule

// ===== src/har_cell.sv =====
`timescale 1ns / 1ps
// One table slot: holds valid bit, IP and MAC, and compares the passing search token.
// Depends on har_pkg.
module har_cell import har_pkg::*; #(
  parameter int unsigned CellIdx = 0
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  har_wr_t  wr_i,
  input  har_tok_t tok_i,
  output har_tok_t tok_o
);

  logic            valid_q;
  logic [IpW-1:0]  ip_q;
  logic [MacW-1:0] mac_q;
  logic            wr_sel;
  logic            match;
  har_tok_t        tok_d, tok_q;

  assign wr_sel = wr_i.en && (32'(wr_i.index) == 32'(CellIdx));
  assign match  = tok_i.rev ? (mac_q == tok_i.key_mac) : (ip_q == tok_i.key_ip);

  always_comb begin
    tok_d = tok_i;
    if (tok_i.active && !tok_i.done) begin
      if (!valid_q) begin
        tok_d.done = 1'b1;
      end else if (match) begin
        tok_d.done    = 1'b1;
        tok_d.hit     = 1'b1;
        tok_d.res_ip  = ip_q;
        tok_d.res_mac = mac_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= '0;
    end else begin
      if (wr_sel) begin
        valid_q <= wr_i.valid;
      end
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_sel) begin
      ip_q  <= wr_i.ip;
      mac_q <= wr_i.mac;
    end
  end

  assign tok_o = tok_q;

endmodule
